@@ src/hdv_pkg.sv @@
`timescale 1ns / 1ps

package hdv_pkg;

    typedef struct packed {
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_z;
        logic signed [15:0] vort_x;
        logic signed [15:0] vort_y;
        logic signed [15:0] vort_z;
        logic               volume_start;
    } t_vox_in;

    typedef struct packed {
        logic signed [31:0] helicity;
        logic signed [31:0] running_low;
        logic signed [31:0] running_high;
        logic               undefined_norm;
    } t_hel_out;

    typedef enum logic [2:0] {
        REG_NORMALIZE_MODE   = 3'd0,
        REG_ABSOLUTE_MODE    = 3'd1,
        REG_VELOCITY_SCALE   = 3'd2,
        REG_VELOCITY_OFFSET  = 3'd3,
        REG_VORTICITY_SCALE  = 3'd4,
        REG_VORTICITY_OFFSET = 3'd5
    } t_reg_idx;

    localparam int ADDR_W = 5;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    localparam logic signed [15:0] SCALE_RESET = 16'sd256;

endpackage

@@ src/helicity_density_voxel_core.sv @@
`timescale 1ns / 1ps

// channel   | valid    | ready    | payload          | transfer when
// ----------+----------+----------+------------------+--------------------------
// voxel in  | i_valid  | o_ready  | i_vox (t_vox_in) | i_valid && o_ready
// result    | o_valid  | i_ready  | o_res (t_hel_out)| o_valid && i_ready
// config    | psel     | pready   | paddr, pwdata    | psel && penable && pwrite
//
// Only normalize mode with both lengths non-zero runs the square roots and the division.
// The cost is set by the single 18x18 multiplier (6 mappings, 9 products, one
// length product) and by one shared subtract/compare unit that runs two 17-step
// square roots and a 20-step division, one bit per cycle.
// Reset clears control, running min/max and the registers to their reset values.
// A finished result waits in the output register; a following voxel is taken.

module helicity_density_voxel_core
    import hdv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_vox_in           i_vox,
    output logic              o_valid,
    input  logic              i_ready,
    output t_hel_out          o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQV,
        ST_SQW,
        ST_DEN,
        ST_DENW,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        TAG_NONE,
        TAG_MAP,
        TAG_DOT,
        TAG_SV,
        TAG_SW,
        TAG_DEN
    } t_tag;

    t_state r_state;

    logic               r_norm;
    logic               r_abs;
    logic signed [15:0] r_vel_scale;
    logic signed [15:0] r_vel_off;
    logic signed [15:0] r_vort_scale;
    logic signed [15:0] r_vort_off;

    t_vox_in            r_in;
    logic [4:0]         r_step;
    logic signed [17:0] r_map [6];

    logic signed [35:0] r_prod;
    t_tag               r_tag;
    logic [2:0]         r_tag_idx;

    logic signed [34:0] r_dot;
    logic [33:0]        r_sv;
    logic [33:0]        r_sw;

    logic [33:0]        r_rad;
    logic [35:0]        r_rem;
    logic [16:0]        r_root;
    logic [16:0]        r_lv;
    logic [16:0]        r_lw;
    logic [33:0]        r_den;
    logic [19:0]        r_quo;
    logic [4:0]         r_cnt;

    logic signed [31:0] r_h;
    logic               r_flag;
    logic signed [31:0] r_min;
    logic signed [31:0] r_max;

    logic               r_out_valid;
    t_hel_out           r_out;

    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    t_tag               mul_tag;
    logic [2:0]         mul_idx;

    logic [35:0]        it_a;
    logic [35:0]        it_b;
    logic [36:0]        it_diff;
    logic               it_ge;
    logic [35:0]        n_rem;
    logic [16:0]        n_root;
    logic [19:0]        n_quo;

    logic signed [32:0] map_rnd;
    logic signed [17:0] map_off;
    logic signed [17:0] map_val;
    logic signed [31:0] dot_sat;
    logic signed [34:0] dot_neg;
    logic [33:0]        dot_mag;
    logic signed [31:0] quo_signed;
    logic signed [31:0] h_fin;
    logic signed [31:0] base_min;
    logic signed [31:0] base_max;
    logic signed [31:0] n_min;
    logic signed [31:0] n_max;
    logic               cfg_wr;

    // multiplier operand select
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_tag = TAG_NONE;
        mul_idx = '0;
        if (r_state == ST_MUL) begin
            case (r_step)
                5'd0: begin
                    mul_a = 18'(r_in.vel_x);  mul_b = 18'(r_vel_scale);
                    mul_tag = TAG_MAP;        mul_idx = 3'd0;
                end
                5'd1: begin
                    mul_a = 18'(r_in.vel_y);  mul_b = 18'(r_vel_scale);
                    mul_tag = TAG_MAP;        mul_idx = 3'd1;
                end
                5'd2: begin
                    mul_a = 18'(r_in.vel_z);  mul_b = 18'(r_vel_scale);
                    mul_tag = TAG_MAP;        mul_idx = 3'd2;
                end
                5'd3: begin
                    mul_a = 18'(r_in.vort_x); mul_b = 18'(r_vort_scale);
                    mul_tag = TAG_MAP;        mul_idx = 3'd3;
                end
                5'd4: begin
                    mul_a = 18'(r_in.vort_y); mul_b = 18'(r_vort_scale);
                    mul_tag = TAG_MAP;        mul_idx = 3'd4;
                end
                5'd5: begin
                    mul_a = 18'(r_in.vort_z); mul_b = 18'(r_vort_scale);
                    mul_tag = TAG_MAP;        mul_idx = 3'd5;
                end
                5'd7:  begin mul_a = r_map[0]; mul_b = r_map[3]; mul_tag = TAG_DOT; end
                5'd8:  begin mul_a = r_map[0]; mul_b = r_map[0]; mul_tag = TAG_SV;  end
                5'd9:  begin mul_a = r_map[3]; mul_b = r_map[3]; mul_tag = TAG_SW;  end
                5'd10: begin mul_a = r_map[1]; mul_b = r_map[4]; mul_tag = TAG_DOT; end
                5'd11: begin mul_a = r_map[1]; mul_b = r_map[1]; mul_tag = TAG_SV;  end
                5'd12: begin mul_a = r_map[4]; mul_b = r_map[4]; mul_tag = TAG_SW;  end
                5'd13: begin mul_a = r_map[2]; mul_b = r_map[5]; mul_tag = TAG_DOT; end
                5'd14: begin mul_a = r_map[2]; mul_b = r_map[2]; mul_tag = TAG_SV;  end
                5'd15: begin mul_a = r_map[5]; mul_b = r_map[5]; mul_tag = TAG_SW;  end
                default: begin
                    mul_tag = TAG_NONE;
                end
            endcase
        end else if (r_state == ST_DEN) begin
            mul_a   = signed'({1'b0, r_lv});
            mul_b   = signed'({1'b0, r_lw});
            mul_tag = TAG_DEN;
        end
    end

    // shared subtract/compare unit: square root and division steps
    always_comb begin
        case (r_state)
            ST_SQV, ST_SQW: begin
                it_a = {r_rem[33:0], r_rad[33:32]};
                it_b = {17'd0, r_root, 2'b01};
            end
            ST_DIV: begin
                it_a = {r_rem[34:0], r_rad[33]};
                it_b = {2'd0, r_den};
            end
            default: begin
                it_a = '0;
                it_b = '0;
            end
        endcase
        it_diff = {1'b0, it_a} - {1'b0, it_b};
        it_ge   = ~it_diff[36];
        n_rem   = it_ge ? it_diff[35:0] : it_a;
        n_root  = {r_root[15:0], it_ge};
        n_quo   = {r_quo[18:0], it_ge};
    end

    always_comb begin
        map_rnd = r_prod[32:0] + 33'sd16384;
        map_off = (r_tag_idx < 3'd3) ? 18'(r_vel_off) : 18'(r_vort_off);
        map_val = map_rnd[32:15] + map_off;

        if ((r_dot[34:31] == 4'b0000) || (r_dot[34:31] == 4'b1111)) begin
            dot_sat = r_dot[31:0];
        end else begin
            dot_sat = r_dot[34] ? SAT_MIN : SAT_MAX;
        end
        dot_neg = -r_dot;
        dot_mag = r_dot[34] ? dot_neg[33:0] : r_dot[33:0];

        quo_signed = signed'({12'd0, n_quo});
        if (r_dot[34]) begin
            quo_signed = -quo_signed;
        end

        if (r_abs && r_h[31]) begin
            h_fin = (r_h == SAT_MIN) ? SAT_MAX : -r_h;
        end else begin
            h_fin = r_h;
        end
        base_min = r_in.volume_start ? '0 : r_min;
        base_max = r_in.volume_start ? '0 : r_max;
        n_min    = (h_fin < base_min) ? h_fin : base_min;
        n_max    = (h_fin > base_max) ? h_fin : base_max;
    end

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    always_comb begin
        case (t_reg_idx'(paddr[ADDR_W-1:2]))
            REG_NORMALIZE_MODE:   prdata = {31'd0, r_norm};
            REG_ABSOLUTE_MODE:    prdata = {31'd0, r_abs};
            REG_VELOCITY_SCALE:   prdata = {16'd0, r_vel_scale};
            REG_VELOCITY_OFFSET:  prdata = {16'd0, r_vel_off};
            REG_VORTICITY_SCALE:  prdata = {16'd0, r_vort_scale};
            REG_VORTICITY_OFFSET: prdata = {16'd0, r_vort_off};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod    <= 36'(mul_a) * 36'(mul_b);
        r_tag_idx <= mul_idx;

        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_tag        <= TAG_NONE;
            r_out_valid  <= 1'b0;
            r_min        <= '0;
            r_max        <= '0;
            r_norm       <= 1'b0;
            r_abs        <= 1'b0;
            r_vel_scale  <= SCALE_RESET;
            r_vel_off    <= '0;
            r_vort_scale <= SCALE_RESET;
            r_vort_off   <= '0;
        end else begin
            r_tag <= mul_tag;

            case (r_tag)
                TAG_MAP: r_map[r_tag_idx] <= map_val;
                TAG_DOT: r_dot <= r_dot + r_prod[34:0];
                TAG_SV:  r_sv  <= r_sv + r_prod[33:0];
                TAG_SW:  r_sw  <= r_sw + r_prod[33:0];
                TAG_DEN: r_den <= r_prod[33:0];
                default: begin
                end
            endcase

            if ((r_state == ST_FIN) && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_in    <= i_vox;
                        r_dot   <= '0;
                        r_sv    <= '0;
                        r_sw    <= '0;
                        r_step  <= '0;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd17) begin
                        if (!r_norm) begin
                            r_h     <= dot_sat;
                            r_flag  <= 1'b0;
                            r_state <= ST_FIN;
                        end else if ((r_sv == '0) || (r_sw == '0)) begin
                            r_h     <= '0;
                            r_flag  <= 1'b1;
                            r_state <= ST_FIN;
                        end else begin
                            r_rad   <= r_sv;
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_cnt   <= 5'd16;
                            r_state <= ST_SQV;
                        end
                    end
                end
                ST_SQV, ST_SQW: begin
                    if (r_cnt != '0) begin
                        r_rem  <= n_rem;
                        r_root <= n_root;
                        r_rad  <= {r_rad[31:0], 2'b00};
                        r_cnt  <= r_cnt - 5'd1;
                    end else if (r_state == ST_SQV) begin
                        r_lv    <= n_root;
                        r_rad   <= r_sw;
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= 5'd16;
                        r_state <= ST_SQW;
                    end else begin
                        r_lw    <= n_root;
                        r_state <= ST_DEN;
                    end
                end
                ST_DEN: begin
                    r_state <= ST_DENW;
                end
                ST_DENW: begin
                    r_rem   <= {6'd0, dot_mag[33:4]};
                    r_rad   <= {dot_mag[3:0], 30'd0};
                    r_quo   <= '0;
                    r_cnt   <= 5'd19;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    r_rad <= {r_rad[32:0], 1'b0};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == '0) begin
                        r_h     <= quo_signed;
                        r_flag  <= 1'b0;
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!r_out_valid || i_ready) begin
                        r_out.helicity       <= h_fin;
                        r_out.running_low    <= n_min;
                        r_out.running_high   <= n_max;
                        r_out.undefined_norm <= r_flag;
                        r_min                <= n_min;
                        r_max                <= n_max;
                        r_state              <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (cfg_wr) begin
                case (t_reg_idx'(paddr[ADDR_W-1:2]))
                    REG_NORMALIZE_MODE:   r_norm       <= pwdata[0];
                    REG_ABSOLUTE_MODE:    r_abs        <= pwdata[0];
                    REG_VELOCITY_SCALE:   r_vel_scale  <= pwdata[15:0];
                    REG_VELOCITY_OFFSET:  r_vel_off    <= pwdata[15:0];
                    REG_VORTICITY_SCALE:  r_vort_scale <= pwdata[15:0];
                    REG_VORTICITY_OFFSET: r_vort_off   <= pwdata[15:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_den != '0))
        else $error("division entered with zero length product");

    a_minmax_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_min[31] || (r_min == '0)) && (!r_max[31]))
        else $error("running min above zero or running max below zero");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.undefined_norm) |-> (o_res.helicity == '0))
        else $error("zero length flagged with non-zero helicity");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready held after a voxel transfer");

endmodule
